FILE: hdl/misct_pkg.sv
// types, codes and default sizes shared by the multiset intersection count table
`timescale 1ns / 1ps

package misct_pkg;

    // default table geometry
    localparam int TABLE_ENTRIES_DEF = 64;
    localparam int COUNT_BITS_DEF    = 16;

    // operation codes
    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_LOAD  = 2'd1;
    localparam logic [1:0] OP_PROBE = 2'd2;

    // status codes
    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_FULL = 2'd1;
    localparam logic [1:0] STATUS_SAT  = 2'd2;

    // input item
    typedef struct packed {
        logic [1:0]         opcode;
        logic signed [31:0] value;
    } item_t;

    // result item
    typedef struct packed {
        logic               hit;
        logic signed [31:0] match_value;
        logic [1:0]         status;
    } result_t;

    // command to the table
    typedef struct packed {
        logic               fire;
        logic [1:0]         opcode;
        logic [31:0]        value;
    } tbl_req_t;

    // answer from the table
    typedef struct packed {
        logic               hit;
        logic [1:0]         status;
    } tbl_rsp_t;

endpackage

FILE: hdl/multiset_intersect_count_table_core.sv
// Multiset intersection count table: one item in, one result out, all entries searched at once.
// Items wait in the item register; lookup and update of all entries load the result register.
// Throughput: one item per cycle while result_stall does not hold back a pending result.
// Reset: valid bits and handshake state clear at once; keys and counts are not reset and
// need no clearing pass, so items are taken from the first cycle after reset.
`timescale 1ns / 1ps

module multiset_intersect_count_table_core #(
    parameter int TABLE_ENTRIES = misct_pkg::TABLE_ENTRIES_DEF,
    parameter int COUNT_BITS    = misct_pkg::COUNT_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  misct_pkg::item_t   item,
    output logic               result_valid,
    input  logic               result_stall,
    output misct_pkg::result_t result
);

    logic                item_valid_reg;
    logic                item_valid_next;
    misct_pkg::item_t    item_reg;
    logic                result_valid_reg;
    logic                result_valid_next;
    misct_pkg::result_t  result_reg;
    misct_pkg::result_t  result_next;
    misct_pkg::tbl_req_t tbl_req;
    misct_pkg::tbl_rsp_t tbl_rsp;
    logic                stage_go;
    logic                item_take;

    // handshake control
    assign stage_go   = item_valid_reg && (!result_valid_reg || !result_stall);
    assign item_stall = item_valid_reg && !stage_go;
    assign item_take  = item_valid && !item_stall;

    // lookup and update
    assign tbl_req.fire   = stage_go;
    assign tbl_req.opcode = item_reg.opcode;
    assign tbl_req.value  = item_reg.value;

    misct_table #(
        .TABLE_ENTRIES(TABLE_ENTRIES),
        .COUNT_BITS   (COUNT_BITS)
    ) u_table (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (tbl_req),
        .rsp  (tbl_rsp)
    );

    // result payload
    always_comb
    begin
        result_next.hit         = tbl_rsp.hit;
        result_next.match_value = tbl_rsp.hit ? item_reg.value : '0;
        result_next.status      = tbl_rsp.status;
    end

    // valid flags of both registers
    always_comb
    begin
        item_valid_next = item_valid_reg;
        if (item_take)
        begin
            item_valid_next = 1'b1;
        end
        else if (stage_go)
        begin
            item_valid_next = 1'b0;
        end

        result_valid_next = result_valid_reg;
        if (stage_go)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg   <= item_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            item_reg <= item;
        end
        if (stage_go)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // a hit never carries a load status
    a_hit_ok: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && result_reg.hit |-> result_reg.status == misct_pkg::STATUS_OK)
        else $error("hit result with non-ok status");

    // a miss reports a zero value
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && !result_reg.hit |-> result_reg.match_value == '0)
        else $error("miss result with non-zero value");

    // a held item is neither lost nor overwritten
    a_item_held: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid_reg && !stage_go |=> item_valid_reg && $stable(item_reg))
        else $error("pending item lost or overwritten");

    // every processed item lands in the result register
    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        stage_go |=> result_valid_reg)
        else $error("processed item produced no result");

endmodule

FILE: hdl/misct_table.sv
// associative count table: parallel key compare, count update and free entry allocation
`timescale 1ns / 1ps

module misct_table #(
    parameter int TABLE_ENTRIES = misct_pkg::TABLE_ENTRIES_DEF,
    parameter int COUNT_BITS    = misct_pkg::COUNT_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  misct_pkg::tbl_req_t req,
    output misct_pkg::tbl_rsp_t rsp
);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

    logic [31:0]            key_reg   [TABLE_ENTRIES];
    logic [COUNT_BITS-1:0]  count_reg [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] valid_reg;
    logic [TABLE_ENTRIES-1:0] valid_next;

    logic [TABLE_ENTRIES-1:0] match_vec;
    logic [TABLE_ENTRIES-1:0] live_vec;
    logic [TABLE_ENTRIES-1:0] sat_vec;
    logic [TABLE_ENTRIES-1:0] free_vec;
    logic [TABLE_ENTRIES-1:0] first_free;
    logic                     any_match;
    logic                     any_live;
    logic                     any_sat;
    logic                     table_full;
    logic                     do_clear;
    logic                     do_load;
    logic                     do_probe;

    // per-entry compare lanes
    always_comb
    begin
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            match_vec[i] = valid_reg[i] && (key_reg[i] == req.value);
            live_vec[i]  = match_vec[i] && (count_reg[i] != '0);
            sat_vec[i]   = match_vec[i] && (count_reg[i] == COUNT_MAX);
        end
    end

    // lowest free entry as a one-hot mask
    assign free_vec   = ~valid_reg;
    assign first_free = free_vec & (~free_vec + TABLE_ENTRIES'(1));
    assign any_match  = |match_vec;
    assign any_live   = |live_vec;
    assign any_sat    = |sat_vec;
    assign table_full = ~|free_vec;

    // operation decode
    always_comb
    begin
        do_clear = 1'b0;
        do_load  = 1'b0;
        do_probe = 1'b0;
        case (req.opcode)
            misct_pkg::OP_CLEAR: do_clear = req.fire;
            misct_pkg::OP_LOAD:  do_load  = req.fire;
            misct_pkg::OP_PROBE: do_probe = req.fire;
            default:             do_clear = 1'b0;
        endcase
    end

    // answer for the result register
    always_comb
    begin
        rsp.hit    = do_probe && any_live;
        rsp.status = misct_pkg::STATUS_OK;
        if (do_load && any_match && any_sat)
        begin
            rsp.status = misct_pkg::STATUS_SAT;
        end
        else if (do_load && !any_match && table_full)
        begin
            rsp.status = misct_pkg::STATUS_FULL;
        end
    end

    // next valid bits
    always_comb
    begin
        valid_next = valid_reg;
        if (do_clear)
        begin
            valid_next = '0;
        end
        else if (do_load && !any_match)
        begin
            valid_next = valid_reg | first_free;
        end
        else if (do_probe)
        begin
            for (int i = 0; i < TABLE_ENTRIES; i++)
            begin
                if (live_vec[i] && (count_reg[i] == COUNT_ONE))
                begin
                    valid_next[i] = 1'b0;
                end
            end
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // keys and counts, one lane per entry
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            if (do_load && !any_match && first_free[i])
            begin
                key_reg[i]   <= req.value;
                count_reg[i] <= COUNT_ONE;
            end
            else if (do_load && match_vec[i] && !sat_vec[i])
            begin
                count_reg[i] <= count_reg[i] + COUNT_ONE;
            end
            else if (do_probe && live_vec[i])
            begin
                count_reg[i] <= count_reg[i] - COUNT_ONE;
            end
        end
    end

endmodule
